// ----- design/ddd_pkg.sv -----
// Shared widths, constants and the month-offset table for the date difference block.
package ddd_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int DIST_W   = 22;
   // Day number of the latest 14-bit year stays below 2**23.
   localparam int DNUM_W   = 23;
   localparam int DOY_W    = 9;
   localparam int QUOT_W   = 8;
   localparam int QUART_W  = 13;

   localparam int DEFAULT_MAX_YEAR = 9999;

   // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2**15
   localparam int PROD_W      = 27;
   localparam int RECIP_SHIFT = 19;
   localparam logic [PROD_W-1:0] RECIP_100 = PROD_W'(5243);

   localparam logic [YEAR_W-1:0] CENTURY    = YEAR_W'(100);
   localparam logic [DNUM_W-1:0] DAYS_YEAR  = DNUM_W'(365);
   localparam logic [MONTH_W-1:0] FEBRUARY  = MONTH_W'(2);

   // Days in the months before month m of a common year; codes 13..15 act as December.
   function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
      logic [DOY_W-1:0] days;
      case (m)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         default: days = 9'd334;
      endcase
      return days;
   endfunction

endpackage

// ----- design/ddd_day_number.sv -----
// Four-stage pipeline that turns one date into its day number counted from year 0.
module ddd_day_number #(
   parameter int MAX_YEAR = ddd_pkg::DEFAULT_MAX_YEAR
) (
   input  logic                           clock,
   input  logic [ddd_pkg::YEAR_W-1:0]     year,
   input  logic [ddd_pkg::MONTH_W-1:0]    month,
   input  logic [ddd_pkg::DAY_W-1:0]      day,
   output logic [ddd_pkg::DNUM_W-1:0]     day_num
);

   localparam int YEAR_TOP = (1 << ddd_pkg::YEAR_W) - 1;
   localparam logic [ddd_pkg::YEAR_W-1:0] YEAR_LIMIT =
      (MAX_YEAR > YEAR_TOP) ? ddd_pkg::YEAR_W'(YEAR_TOP) : ddd_pkg::YEAR_W'(MAX_YEAR);
   localparam int YP_W = ddd_pkg::YEAR_W + 1;

   // stage 1: clamped date
   logic [ddd_pkg::YEAR_W-1:0]  s1_year_ff, s1_year_in;
   logic [ddd_pkg::MONTH_W-1:0] s1_month_ff;
   logic [ddd_pkg::DAY_W-1:0]   s1_day_ff;

   // stage 2: products and quotients
   logic [ddd_pkg::DNUM_W-1:0]  s2_y365_ff, s2_y365_in;
   logic [ddd_pkg::QUART_W-1:0] s2_c4_ff, s2_c4_in;
   logic [ddd_pkg::QUOT_W-1:0]  s2_c100_ff, s2_c100_in;
   logic [ddd_pkg::QUOT_W-1:0]  s2_c400_ff, s2_c400_in;
   logic [ddd_pkg::QUOT_W-1:0]  s2_q100_ff, s2_q100_in;
   logic [ddd_pkg::YEAR_W-1:0]  s2_year_ff;
   logic [ddd_pkg::DOY_W-1:0]   s2_doy_ff, s2_doy_in;
   logic                        s2_late_ff, s2_late_in;

   // stage 3: whole-year days and day of year
   logic [ddd_pkg::DNUM_W-1:0]  s3_years_ff, s3_years_in;
   logic [ddd_pkg::DOY_W-1:0]   s3_doy_ff, s3_doy_in;

   // stage 4: day number
   logic [ddd_pkg::DNUM_W-1:0]  s4_num_ff, s4_num_in;

   logic [YP_W-1:0]                 yp99, yp399;
   logic [ddd_pkg::PROD_W-1:0]      prod_q, prod_c100, prod_c400;
   logic                            leap;

   assign s1_year_in = (year > YEAR_LIMIT) ? YEAR_LIMIT : year;

   always_comb begin
      yp99       = YP_W'(s1_year_ff) + YP_W'(99);
      yp399      = YP_W'(s1_year_ff) + YP_W'(399);
      prod_q     = ddd_pkg::PROD_W'(s1_year_ff) * ddd_pkg::RECIP_100;
      prod_c100  = ddd_pkg::PROD_W'(yp99) * ddd_pkg::RECIP_100;
      // (y + 399) / 400 is ((y + 399) / 4) / 100
      prod_c400  = ddd_pkg::PROD_W'(yp399[YP_W-1:2]) * ddd_pkg::RECIP_100;
      s2_q100_in = prod_q[ddd_pkg::RECIP_SHIFT +: ddd_pkg::QUOT_W];
      s2_c100_in = prod_c100[ddd_pkg::RECIP_SHIFT +: ddd_pkg::QUOT_W];
      s2_c400_in = prod_c400[ddd_pkg::RECIP_SHIFT +: ddd_pkg::QUOT_W];
      s2_y365_in = ddd_pkg::DNUM_W'(s1_year_ff) * ddd_pkg::DAYS_YEAR;
      s2_c4_in   = ddd_pkg::QUART_W'((YP_W'(s1_year_ff) + YP_W'(3)) >> 2);
      s2_doy_in  = ddd_pkg::days_before_month(s1_month_ff) + ddd_pkg::DOY_W'(s1_day_ff);
      s2_late_in = (s1_month_ff > ddd_pkg::FEBRUARY);
   end

   always_comb begin
      // divisible by 100 only counts when the century is divisible by 4
      leap = (s2_year_ff[1:0] == 2'b00) &&
             ((ddd_pkg::YEAR_W'(s2_q100_ff) * ddd_pkg::CENTURY != s2_year_ff) ||
              (s2_q100_ff[1:0] == 2'b00));
      s3_years_in = s2_y365_ff + ddd_pkg::DNUM_W'(s2_c4_ff) + ddd_pkg::DNUM_W'(s2_c400_ff)
                    - ddd_pkg::DNUM_W'(s2_c100_ff);
      s3_doy_in   = s2_doy_ff + ddd_pkg::DOY_W'(s2_late_ff && leap);
      s4_num_in   = s3_years_ff + ddd_pkg::DNUM_W'(s3_doy_ff);
   end

   always_ff @(posedge clock) begin
      s1_year_ff  <= s1_year_in;
      s1_month_ff <= month;
      s1_day_ff   <= day;
      s2_y365_ff  <= s2_y365_in;
      s2_c4_ff    <= s2_c4_in;
      s2_c100_ff  <= s2_c100_in;
      s2_c400_ff  <= s2_c400_in;
      s2_q100_ff  <= s2_q100_in;
      s2_year_ff  <= s1_year_ff;
      s2_doy_ff   <= s2_doy_in;
      s2_late_ff  <= s2_late_in;
      s3_years_ff <= s3_years_in;
      s3_doy_ff   <= s3_doy_in;
      s4_num_ff   <= s4_num_in;
   end

   assign day_num = s4_num_ff;

endmodule

// ----- design/date_difference_days_top.sv -----
// An accepted beat passes the day-number pipelines and the distance register to rsp_valid.
// Throughput: one beat per cycle; busy is never raised, the five stages always advance.
// The rate is set by the day-number pipeline (constant reciprocal multiplies, then sums).
// Reset clears the valid bits only; data registers are left as they are.
// Results are strobed for one cycle and cannot be stalled by the receiver.
module date_difference_days_top #(
   parameter int MAX_YEAR = ddd_pkg::DEFAULT_MAX_YEAR
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [ddd_pkg::YEAR_W-1:0]   req_first_year,
   input  logic [ddd_pkg::MONTH_W-1:0]  req_first_month,
   input  logic [ddd_pkg::DAY_W-1:0]    req_first_day,
   input  logic [ddd_pkg::YEAR_W-1:0]   req_second_year,
   input  logic [ddd_pkg::MONTH_W-1:0]  req_second_month,
   input  logic [ddd_pkg::DAY_W-1:0]    req_second_day,
   output logic                         rsp_valid,
   output logic [ddd_pkg::DIST_W-1:0]   rsp_day_distance
);

   localparam int DEPTH = 5;

   logic [DEPTH-1:0]             vld_ff, vld_in;
   logic [ddd_pkg::DNUM_W-1:0]   num_a, num_b, diff;
   logic [ddd_pkg::DIST_W-1:0]   dist_ff, dist_in;

   assign busy = 1'b0;

   ddd_day_number #(.MAX_YEAR(MAX_YEAR)) u_first (
      .clock   (clock),
      .year    (req_first_year),
      .month   (req_first_month),
      .day     (req_first_day),
      .day_num (num_a)
   );

   ddd_day_number #(.MAX_YEAR(MAX_YEAR)) u_second (
      .clock   (clock),
      .year    (req_second_year),
      .month   (req_second_month),
      .day     (req_second_day),
      .day_num (num_b)
   );

   always_comb begin
      vld_in  = {vld_ff[DEPTH-2:0], start & ~busy};
      diff    = (num_a >= num_b) ? (num_a - num_b) : (num_b - num_a);
      // saturate anything past the 22-bit range
      dist_in = diff[ddd_pkg::DNUM_W-1] ? '1 : diff[ddd_pkg::DIST_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
   end

   assign rsp_valid        = vld_ff[DEPTH-1];
   assign rsp_day_distance = dist_ff;

endmodule

// ----- dv/ddd_distance_checker.sv -----
// Watches the date pair and distance channels, predicts each distance and compares.
module ddd_distance_checker #(
   parameter int MAX_YEAR = ddd_pkg::DEFAULT_MAX_YEAR
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [ddd_pkg::YEAR_W-1:0]   req_first_year,
   input  logic [ddd_pkg::MONTH_W-1:0]  req_first_month,
   input  logic [ddd_pkg::DAY_W-1:0]    req_first_day,
   input  logic [ddd_pkg::YEAR_W-1:0]   req_second_year,
   input  logic [ddd_pkg::MONTH_W-1:0]  req_second_month,
   input  logic [ddd_pkg::DAY_W-1:0]    req_second_day,
   input  logic                         rsp_valid,
   input  logic [ddd_pkg::DIST_W-1:0]   rsp_day_distance,
   output int                           mismatch_count,
   output int                           beats_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import ddd_pkg::*;

   localparam longint DIST_CAP = (longint'(1) << DIST_W) - 1;

   logic [DIST_W-1:0] distance_expected[$];
   logic [DIST_W-1:0] oldest_distance;

   // Days from the start of year 0 through the given date; bad days and months are not fixed up.
   function automatic longint days_since_epoch(input logic [YEAR_W-1:0] year_in,
                                               input logic [MONTH_W-1:0] month,
                                               input logic [DAY_W-1:0] day);
      longint yr;
      longint total;
      int     last_month;
      bit     leap;
      yr = (longint'(year_in) > MAX_YEAR) ? longint'(MAX_YEAR) : longint'(year_in);
      leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
      total = 365 * yr + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400;
      // months 13..15 count eleven earlier months, like December
      last_month = (month > 4'd12) ? 12 : int'(month);
      for (int k = 1; k < last_month; k++) begin
         total += (k == 2) ? 28 : ((k == 4 || k == 6 || k == 9 || k == 11) ? 30 : 31);
      end
      if (month > FEBRUARY && leap) begin
         total += 1;
      end
      return total + longint'(day);
   endfunction

   function automatic logic [DIST_W-1:0] predict_distance(
      input logic [YEAR_W-1:0] y1, input logic [MONTH_W-1:0] m1, input logic [DAY_W-1:0] d1,
      input logic [YEAR_W-1:0] y2, input logic [MONTH_W-1:0] m2, input logic [DAY_W-1:0] d2);
      longint a;
      longint b;
      longint gap_days;
      a = days_since_epoch(y1, m1, d1);
      b = days_since_epoch(y2, m2, d2);
      gap_days = (a > b) ? (a - b) : (b - a);
      if (gap_days > DIST_CAP) begin
         gap_days = DIST_CAP;
      end
      return DIST_W'(gap_days);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         distance_expected.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid) begin
            if (distance_expected.size() == 0) begin
               $error("day_distance: got 0x%0h with no beat outstanding", rsp_day_distance);
               mismatch_count++;
            end else begin
               oldest_distance = distance_expected.pop_front();
               if (rsp_day_distance !== oldest_distance) begin
                  $error("day_distance: expected %0d, actual %0d",
                         oldest_distance, rsp_day_distance);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            distance_expected.push_back(predict_distance(
               req_first_year, req_first_month, req_first_day,
               req_second_year, req_second_month, req_second_day));
         end
      end
      beats_outstanding = distance_expected.size();
   end

endmodule

// ----- dv/tb.sv -----
// Stimulus and verdict for the date difference block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ddd_pkg::*;

   localparam int RANDOM_BEATS = 1950;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 12;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [YEAR_W-1:0]   req_first_year = '0;
   logic [MONTH_W-1:0]  req_first_month = '0;
   logic [DAY_W-1:0]    req_first_day = '0;
   logic [YEAR_W-1:0]   req_second_year = '0;
   logic [MONTH_W-1:0]  req_second_month = '0;
   logic [DAY_W-1:0]    req_second_day = '0;
   logic                rsp_valid;
   logic [DIST_W-1:0]   rsp_day_distance;
   int                  mismatch_count;
   int                  beats_outstanding;
   int                  cycle_count = 0;
   int                  burst_left = 0;

   date_difference_days_top #(.MAX_YEAR(DEFAULT_MAX_YEAR)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_first_year(req_first_year), .req_first_month(req_first_month),
      .req_first_day(req_first_day), .req_second_year(req_second_year),
      .req_second_month(req_second_month), .req_second_day(req_second_day),
      .rsp_valid(rsp_valid), .rsp_day_distance(rsp_day_distance)
   );

   ddd_distance_checker #(.MAX_YEAR(DEFAULT_MAX_YEAR)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_first_year(req_first_year), .req_first_month(req_first_month),
      .req_first_day(req_first_day), .req_second_year(req_second_year),
      .req_second_month(req_second_month), .req_second_day(req_second_day),
      .rsp_valid(rsp_valid), .rsp_day_distance(rsp_day_distance),
      .mismatch_count(mismatch_count), .beats_outstanding(beats_outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Mostly no idle, some short gaps, a few long ones, and idle-free bursts.
   function automatic int pick_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Present one date pair, hold it until accepted, then idle for the gap.
   task automatic send_dates(input logic [YEAR_W-1:0] y1, input logic [MONTH_W-1:0] m1,
                             input logic [DAY_W-1:0] d1, input logic [YEAR_W-1:0] y2,
                             input logic [MONTH_W-1:0] m2, input logic [DAY_W-1:0] d2);
      int gap;
      gap = pick_gap();
      req_first_year   <= y1;
      req_first_month  <= m1;
      req_first_day    <= d1;
      req_second_year  <= y2;
      req_second_month <= m2;
      req_second_day   <= d2;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      logic [YEAR_W-1:0]  y1;
      logic [YEAR_W-1:0]  y2;
      int                 kind;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_dates(14'd1, 4'd1, 5'd1, 14'd1, 4'd1, 5'd1);
      send_dates(14'd9999, 4'd12, 5'd31, 14'd1, 4'd1, 5'd1);
      send_dates(14'd0, 4'd1, 5'd1, 14'd16383, 4'd15, 5'd31);
      send_dates(14'd2000, 4'd2, 5'd28, 14'd2000, 4'd3, 5'd1);
      send_dates(14'd1900, 4'd2, 5'd28, 14'd1900, 4'd3, 5'd1);
      send_dates(14'd2004, 4'd2, 5'd29, 14'd2004, 4'd3, 5'd1);
      // Feb 31 lands after Mar 1: reversed order inside one year
      send_dates(14'd2003, 4'd2, 5'd31, 14'd2003, 4'd3, 5'd1);
      send_dates(14'd2023, 4'd0, 5'd0, 14'd2023, 4'd1, 5'd1);
      send_dates(14'd2023, 4'd13, 5'd5, 14'd2023, 4'd12, 5'd5);
      send_dates(14'd2023, 4'd14, 5'd31, 14'd2024, 4'd1, 5'd1);
      send_dates(14'd10000, 4'd6, 5'd15, 14'd9999, 4'd6, 5'd15);
      send_dates(14'd16383, 4'd15, 5'd31, 14'd0, 4'd0, 5'd0);
      send_dates(14'd0, 4'd3, 5'd1, 14'd0, 4'd2, 5'd29);
      send_dates(14'd1, 4'd1, 5'd1, 14'd0, 4'd12, 5'd31);
      send_dates(14'd400, 4'd3, 5'd1, 14'd399, 4'd3, 5'd1);
      send_dates(14'd8191, 4'd8, 5'd16, 14'd4096, 4'd4, 5'd8);
      send_dates(14'h1555, 4'd10, 5'd21, 14'h2AAA, 4'd5, 5'd10);
      send_dates(14'd2024, 4'd12, 5'd31, 14'd2024, 4'd1, 5'd1);
      send_dates(14'd1970, 4'd1, 5'd1, 14'd2038, 4'd1, 5'd19);

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            send_dates(YEAR_W'($urandom_range(1, 9999)), MONTH_W'($urandom_range(1, 12)),
                       DAY_W'($urandom_range(1, 31)), YEAR_W'($urandom_range(1, 9999)),
                       MONTH_W'($urandom_range(1, 12)), DAY_W'($urandom_range(1, 31)));
         end else if (kind < 80) begin
            // close pairs: same or adjacent year, stresses leap and month-order effects
            y1 = YEAR_W'($urandom_range(1, 9998));
            y2 = y1 + YEAR_W'($urandom_range(0, 1));
            send_dates(y1, MONTH_W'($urandom_range(1, 12)), DAY_W'($urandom_range(1, 31)),
                       y2, MONTH_W'($urandom_range(1, 12)), DAY_W'($urandom_range(1, 31)));
         end else begin
            send_dates(YEAR_W'($urandom), MONTH_W'($urandom), DAY_W'($urandom),
                       YEAR_W'($urandom), MONTH_W'($urandom), DAY_W'($urandom));
         end
      end
      start <= 1'b0;

      do @(posedge clock); while (beats_outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && beats_outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
